@@ rtl/bole_pkg.sv @@
// Package for the bounded ordered list engine: operation and status codes,
// controller states and the request and response beat structs.
// Depends on nothing; every RTL file of the block imports it.
`default_nettype none

package bole_pkg;

   localparam int BOLE_DEPTH      = 16;
   localparam int BOLE_DATA_WIDTH = 32;
   localparam int WORD_W          = 32;
   localparam int POS_W           = 5;

   typedef enum logic [3:0] {
      OP_PUSH_FRONT = 4'd0,
      OP_PUSH_BACK  = 4'd1,
      OP_POP_FRONT  = 4'd2,
      OP_POP_BACK   = 4'd3,
      OP_INSERT     = 4'd4,
      OP_REMOVE     = 4'd5,
      OP_READ       = 4'd6,
      OP_REVERSE    = 4'd7,
      OP_CLEAR      = 4'd8
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_RANGE = 2'd2,
      ST_FULL  = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_POPF_LINK,
      S_POPF_DATA,
      S_POPB_LINK,
      S_POPB_DATA,
      S_WALK,
      S_TARGET,
      S_LINK,
      S_REVERSE,
      S_RESP
   } state_type;

   typedef struct packed {
      logic [3:0]         mode;
      logic signed [31:0] value;
      logic [4:0]         position;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result_value;
      status_type         status;
      logic signed [31:0] front_value;
      logic signed [31:0] back_value;
      logic [4:0]         count;
   } rsp_type;

endpackage

`default_nettype wire

@@ rtl/bounded_ordered_list_engine_core.sv @@
// Bounded ordered list engine: doubly linked list held in three slot memories.
// Depends on bole_pkg for codes, states and beat structs.
//
//   channel | ports                  | handshake
//   request | start, busy, req_data  | beat taken when start && !busy
//   result  | rsp_strobe, rsp_data   | one cycle, cannot be held off
//
// Push, pop, clear and out-of-range items need no walk; read and remove in the
// middle walk next links from the head, insert also links the new slot in;
// reverse swaps the links of each node in turn. Each walk step is one read of
// the next-link memory. busy stays high from accept through the result strobe.
// Reset is synchronous and leaves the list empty; no clearing pass is needed.
`default_nettype none

module bounded_ordered_list_engine_core
   import bole_pkg::*;
#(
   parameter int DEPTH      = BOLE_DEPTH,
   parameter int DATA_WIDTH = BOLE_DATA_WIDTH
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_strobe,
   output rsp_type      rsp_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int PW = (CW > POS_W) ? CW : POS_W;
   localparam int XW = (DATA_WIDTH > WORD_W) ? DATA_WIDTH : WORD_W;

   logic [DATA_WIDTH-1:0] elem_mem [DEPTH];
   logic [AW-1:0]         next_mem [DEPTH];
   logic [AW-1:0]         prev_mem [DEPTH];

   logic                  e_we, n_we, p_we;
   logic [AW-1:0]         e_wa, n_wa, p_wa, e_ra, n_ra, p_ra;
   logic [DATA_WIDTH-1:0] e_wd;
   logic [AW-1:0]         n_wd, p_wd;
   logic [DATA_WIDTH-1:0] e_q_ff;
   logic [AW-1:0]         n_q_ff, p_q_ff;

   state_type             state_ff, state_in;
   logic [AW-1:0]         head_ff, head_in, tail_ff, tail_in;
   logic [AW-1:0]         ptr_ff, ptr_in, before_ff, before_in, slot_ff, slot_in;
   logic [CW-1:0]         count_ff, count_in, rem_ff, rem_in;
   logic [DEPTH-1:0]      free_ff, free_in;
   logic [DATA_WIDTH-1:0] front_ff, front_in, back_ff, back_in, val_ff, val_in;
   logic [WORD_W-1:0]     res_ff, res_in;
   status_type            status_ff, status_in;
   logic [3:0]            op_ff, op_in;

   logic [AW-1:0]         fs;
   logic                  full, empty;
   logic [PW-1:0]         pos_x, cnt_x;
   logic [XW-1:0]         val_x;
   logic [DATA_WIDTH-1:0] req_val;

   function automatic logic [WORD_W-1:0] word_of(input logic [DATA_WIDTH-1:0] d);
      logic [XW-1:0] t;
      t = XW'(d);
      return t[WORD_W-1:0];
   endfunction

   always_ff @(posedge clock) begin
      if (e_we) elem_mem[e_wa] <= e_wd;
      e_q_ff <= elem_mem[e_ra];
   end

   always_ff @(posedge clock) begin
      if (n_we) next_mem[n_wa] <= n_wd;
      n_q_ff <= next_mem[n_ra];
   end

   always_ff @(posedge clock) begin
      if (p_we) prev_mem[p_wa] <= p_wd;
      p_q_ff <= prev_mem[p_ra];
   end

   always_comb begin
      fs = '0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (free_ff[i]) fs = AW'(i);
      end
   end

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign pos_x   = PW'(req_data.position);
   assign cnt_x   = PW'(count_ff);
   assign val_x   = XW'($unsigned(req_data.value));
   assign req_val = val_x[DATA_WIDTH-1:0];

   always_comb begin
      state_in  = state_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      ptr_in    = ptr_ff;
      before_in = before_ff;
      slot_in   = slot_ff;
      count_in  = count_ff;
      rem_in    = rem_ff;
      free_in   = free_ff;
      front_in  = front_ff;
      back_in   = back_ff;
      val_in    = val_ff;
      res_in    = res_ff;
      status_in = status_ff;
      op_in     = op_ff;
      e_we = 1'b0; e_wa = '0; e_wd = '0; e_ra = '0;
      n_we = 1'b0; n_wa = '0; n_wd = '0; n_ra = '0;
      p_we = 1'b0; p_wa = '0; p_wd = '0; p_ra = '0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in     = req_data.mode;
               val_in    = req_val;
               res_in    = '0;
               status_in = ST_OK;
               state_in  = S_RESP;
               case (req_data.mode)
                  OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT: begin
                     if (req_data.mode == OP_INSERT && pos_x > cnt_x) begin
                        status_in = ST_RANGE;
                     end else if (full) begin
                        status_in = ST_FULL;
                     end else if (req_data.mode == OP_PUSH_FRONT ||
                                  (req_data.mode == OP_INSERT && pos_x == '0)) begin
                        e_we = 1'b1; e_wa = fs; e_wd = req_val;
                        n_we = !empty; n_wa = fs; n_wd = head_ff;
                        p_we = !empty; p_wa = head_ff; p_wd = fs;
                        if (empty) begin
                           tail_in = fs;
                           back_in = req_val;
                        end
                        head_in     = fs;
                        front_in    = req_val;
                        count_in    = count_ff + 1'b1;
                        free_in[fs] = 1'b0;
                     end else if (req_data.mode == OP_PUSH_BACK || pos_x == cnt_x) begin
                        e_we = 1'b1; e_wa = fs; e_wd = req_val;
                        p_we = !empty; p_wa = fs; p_wd = tail_ff;
                        n_we = !empty; n_wa = tail_ff; n_wd = fs;
                        if (empty) begin
                           head_in  = fs;
                           front_in = req_val;
                        end
                        tail_in     = fs;
                        back_in     = req_val;
                        count_in    = count_ff + 1'b1;
                        free_in[fs] = 1'b0;
                     end else begin
                        n_ra     = head_ff;
                        rem_in   = CW'(pos_x);
                        state_in = S_WALK;
                     end
                  end
                  OP_POP_FRONT, OP_POP_BACK, OP_REMOVE, OP_READ: begin
                     if (empty) begin
                        status_in = ST_EMPTY;
                     end else if ((req_data.mode == OP_REMOVE || req_data.mode == OP_READ)
                                  && pos_x >= cnt_x) begin
                        status_in = ST_RANGE;
                     end else if (req_data.mode == OP_READ) begin
                        if (pos_x == '0) begin
                           res_in = word_of(front_ff);
                        end else if (pos_x == cnt_x - 1'b1) begin
                           res_in = word_of(back_ff);
                        end else begin
                           n_ra     = head_ff;
                           rem_in   = CW'(pos_x);
                           state_in = S_WALK;
                        end
                     end else if (req_data.mode == OP_POP_FRONT ||
                                  (req_data.mode == OP_REMOVE && pos_x == '0)) begin
                        res_in           = word_of(front_ff);
                        free_in[head_ff] = 1'b1;
                        count_in         = count_ff - 1'b1;
                        if (count_ff == CW'(1)) begin
                           head_in = '0;
                           tail_in = '0;
                        end else begin
                           n_ra     = head_ff;
                           state_in = S_POPF_LINK;
                        end
                     end else if (req_data.mode == OP_POP_BACK || pos_x == cnt_x - 1'b1) begin
                        res_in           = word_of(back_ff);
                        free_in[tail_ff] = 1'b1;
                        count_in         = count_ff - 1'b1;
                        if (count_ff == CW'(1)) begin
                           head_in = '0;
                           tail_in = '0;
                        end else begin
                           p_ra     = tail_ff;
                           state_in = S_POPB_LINK;
                        end
                     end else begin
                        n_ra     = head_ff;
                        rem_in   = CW'(pos_x);
                        state_in = S_WALK;
                     end
                  end
                  OP_REVERSE: begin
                     if (!empty) begin
                        head_in  = tail_ff;
                        tail_in  = head_ff;
                        front_in = back_ff;
                        back_in  = front_ff;
                        ptr_in   = head_ff;
                        n_ra     = head_ff;
                        p_ra     = head_ff;
                        rem_in   = count_ff;
                        state_in = S_REVERSE;
                     end
                  end
                  OP_CLEAR: begin
                     free_in  = '1;
                     head_in  = '0;
                     tail_in  = '0;
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_POPF_LINK: begin
            head_in  = n_q_ff;
            e_ra     = n_q_ff;
            state_in = S_POPF_DATA;
         end
         S_POPF_DATA: begin
            front_in = e_q_ff;
            state_in = S_RESP;
         end
         S_POPB_LINK: begin
            tail_in  = p_q_ff;
            e_ra     = p_q_ff;
            state_in = S_POPB_DATA;
         end
         S_POPB_DATA: begin
            back_in  = e_q_ff;
            state_in = S_RESP;
         end
         S_WALK: begin
            rem_in = rem_ff - 1'b1;
            if (rem_ff == CW'(1)) begin
               ptr_in   = n_q_ff;
               e_ra     = n_q_ff;
               n_ra     = n_q_ff;
               p_ra     = n_q_ff;
               state_in = S_TARGET;
            end else begin
               n_ra = n_q_ff;
            end
         end
         S_TARGET: begin
            state_in = S_RESP;
            case (op_ff)
               OP_INSERT: begin
                  e_we = 1'b1; e_wa = fs; e_wd = val_ff;
                  n_we = 1'b1; n_wa = fs; n_wd = ptr_ff;
                  p_we = 1'b1; p_wa = fs; p_wd = p_q_ff;
                  before_in   = p_q_ff;
                  slot_in     = fs;
                  free_in[fs] = 1'b0;
                  count_in    = count_ff + 1'b1;
                  state_in    = S_LINK;
               end
               OP_REMOVE: begin
                  res_in          = word_of(e_q_ff);
                  n_we = 1'b1; n_wa = p_q_ff; n_wd = n_q_ff;
                  p_we = 1'b1; p_wa = n_q_ff; p_wd = p_q_ff;
                  free_in[ptr_ff] = 1'b1;
                  count_in        = count_ff - 1'b1;
               end
               default: begin
                  res_in = word_of(e_q_ff);
               end
            endcase
         end
         S_LINK: begin
            n_we = 1'b1; n_wa = before_ff; n_wd = slot_ff;
            p_we = 1'b1; p_wa = ptr_ff;    p_wd = slot_ff;
            state_in = S_RESP;
         end
         S_REVERSE: begin
            n_we = 1'b1; n_wa = ptr_ff; n_wd = p_q_ff;
            p_we = 1'b1; p_wa = ptr_ff; p_wd = n_q_ff;
            rem_in = rem_ff - 1'b1;
            if (rem_ff == CW'(1)) begin
               state_in = S_RESP;
            end else begin
               ptr_in = n_q_ff;
               n_ra   = n_q_ff;
               p_ra   = n_q_ff;
            end
         end
         S_RESP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
         free_ff  <= '1;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         free_ff  <= free_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff    <= ptr_in;
      before_ff <= before_in;
      slot_ff   <= slot_in;
      rem_ff    <= rem_in;
      front_ff  <= front_in;
      back_ff   <= back_in;
      val_ff    <= val_in;
      res_ff    <= res_in;
      status_ff <= status_in;
      op_ff     <= op_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = (state_ff == S_RESP);

   always_comb begin
      rsp_data.result_value = res_ff;
      rsp_data.status       = status_ff;
      rsp_data.front_value  = empty ? '0 : word_of(front_ff);
      rsp_data.back_value   = empty ? '0 : word_of(back_ff);
      rsp_data.count        = cnt_x[POS_W-1:0];
   end

endmodule

`default_nettype wire
